// ===== hw/rtl/indexed_operand_stack_defines.svh =====
// Assertion macros for the indexed operand stack.
// Used by indexed_operand_stack.sv; expects clk_i and rst_ni in scope.
`ifndef INDEXED_OPERAND_STACK_DEFINES_SVH
`define INDEXED_OPERAND_STACK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IOS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ios: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IOS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ios: next-cycle check failed");

`endif

// ===== hw/rtl/ios_pkg.sv =====
// Shared types and codes for the indexed operand stack.
// No dependencies; used by the interfaces, sequencer and top level.
`default_nettype none

package ios_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned TypeW   = 3;
  localparam int unsigned ActionW = 4;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CountW  = 6;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH   = 4'd0,
    ACT_INSERT = 4'd1,
    ACT_POP    = 4'd2,
    ACT_CLEAR  = 4'd3,
    ACT_DUP    = 4'd4,
    ACT_SWAP   = 4'd5,
    ACT_READ   = 4'd6,
    ACT_REMOVE = 4'd7,
    ACT_PRINT  = 4'd8,
    ACT_DUMP   = 4'd9
  } action_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_FEW      = 3'd1,
    ERR_RANGE    = 3'd2,
    ERR_NOT_INT8 = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_e;

  localparam logic [TypeW-1:0] TYPE_INT8 = 3'd0;

  // One stack entry as stored in the RAM.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [TypeW-1:0]         etype;
  } entry_t;

  // One result on its way to the output register.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [TypeW-1:0]         etype;
    err_e                     err;
    logic [CountW-1:0]        count;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ios_if.sv =====
// Valid/ready channel interfaces of the indexed operand stack.
// Field widths come from ios_pkg.
`default_nettype none

interface ios_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [ios_pkg::ActionW-1:0]           action;
  logic [ios_pkg::PosW-1:0]              position;
  logic signed [ios_pkg::ValueW-1:0]     operand_value;
  logic [ios_pkg::TypeW-1:0]             operand_type;

  modport source (output valid, action, position, operand_value, operand_type,
                  input ready);
  modport sink   (input valid, action, position, operand_value, operand_type,
                  output ready);
endinterface

interface ios_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ios_pkg::ValueW-1:0]     entry_value;
  logic [ios_pkg::TypeW-1:0]             entry_type;
  logic [2:0]                            error_code;
  logic [ios_pkg::CountW-1:0]            stack_count;
  logic                                  last_result;

  modport source (output valid, entry_value, entry_type, error_code, stack_count,
                  last_result, input ready);
  modport sink   (input valid, entry_value, entry_type, error_code, stack_count,
                  last_result, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/indexed_operand_stack.sv =====
// Indexed operand stack top level: sequencer plus output register.
// Depends on ios_pkg, ios_if, ios_ram, ios_seq and the defines header.
//
// Usage:
//   in_i  (sink): one transfer carries one action (push, insert, pop, clear,
//         dup, swap, read, remove, print, dump) with position and operand.
//   out_o (source): result transfers. Every action gives one result; dump
//         gives one per entry (one if empty), top first, with last_result on the final one.
//   Entries live in one RAM (value and type side by side, one write and one
//   registered read port); index 0 is the top, the bottom sits at address 0.
//   One action is in flight at a time: in_i.ready is high only while idle.
//   Path from input transfer to result in the output register: push, pop,
//   clear, errors and unknown codes go straight from decode to the result;
//   dup, print and read first take one RAM read; swap reads both top entries
//   and writes them back crosswise; insert or remove at index p moves p
//   entries with one RAM read/write each. Dump reads each entry, then hands
//   it off, top first. The next input transfer can come in the cycle after the last result is handed off.
//   The output register frees the sequencer: the next action is accepted
//   while a result still waits on out_o. If out_o stalls, the sequencer
//   holds its result and stops until the register drains.
//   Reset clears the entry count and all control; RAM contents are not
//   cleared, only entries below the count are ever read.
`default_nettype none

module indexed_operand_stack #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ios_in_if.sink    in_i,
  ios_out_if.source out_o
);

`include "indexed_operand_stack_defines.svh"

  logic             res_valid;
  logic             res_ready;
  ios_pkg::result_t res;

  logic             out_valid_q;
  ios_pkg::result_t out_data_q;

  ios_seq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output register: refills in the cycle it drains.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.entry_value = out_data_q.value;
  assign out_o.entry_type  = out_data_q.etype;
  assign out_o.error_code  = out_data_q.err;
  assign out_o.stack_count = out_data_q.count;
  assign out_o.last_result = out_data_q.last;

  // One action at a time: an input transfer closes the input.
  `IOS_ASSERT_NXT(a_one_in_flight, in_i.valid && in_i.ready, !in_i.ready)
  // Failed actions return no entry data.
  `IOS_ASSERT_IMP(a_err_no_data, res_valid && (res.err != ios_pkg::ERR_OK),
                  (res.value == '0) && (res.etype == '0))
  // Only a dump emits non-final results, and those never fail.
  `IOS_ASSERT_IMP(a_mid_ok, res_valid && !res.last, res.err == ios_pkg::ERR_OK)
  // A handed-off result lands in the output register.
  `IOS_ASSERT_NXT(a_handoff, res_valid && res_ready, out_valid_q)

endmodule

`default_nettype wire

// ===== hw/rtl/ios_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ios_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ios_seq.sv =====
// Sequencer of the indexed operand stack: decodes one action, walks the
// entry RAM (read, modify, write back) and hands results out one by one.
// Depends on ios_pkg, ios_if and ios_ram.
`default_nettype none

module ios_seq #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ios_in_if.sink           in_i,
  output logic             res_valid_o,
  output ios_pkg::result_t res_o,
  input  wire logic        res_ready_i
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CmpW = (CntW > ios_pkg::PosW) ? CntW : ios_pkg::PosW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_UP     = 4'd2;
  localparam logic [3:0] S_PLACE  = 4'd3;
  localparam logic [3:0] S_DUPW   = 4'd4;
  localparam logic [3:0] S_SWAP1  = 4'd5;
  localparam logic [3:0] S_SWAP2  = 4'd6;
  localparam logic [3:0] S_SWAP3  = 4'd7;
  localparam logic [3:0] S_FETCH  = 4'd8;
  localparam logic [3:0] S_DOWN   = 4'd9;
  localparam logic [3:0] S_PRINT  = 4'd10;
  localparam logic [3:0] S_DUMP   = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  logic [3:0]                        state_q, state_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic [AddrW-1:0]                  ptr_q, ptr_d;
  logic [CntW-1:0]                   rem_q, rem_d;
  ios_pkg::entry_t                   tmp_q, tmp_d;
  ios_pkg::result_t                  res_q, res_d;

  logic [ios_pkg::ActionW-1:0]       act_q;
  logic [ios_pkg::PosW-1:0]          pos_q;
  logic signed [ios_pkg::ValueW-1:0] val_q;
  logic [ios_pkg::TypeW-1:0]         typ_q;

  logic                              ram_we, ram_re;
  logic [AddrW-1:0]                  ram_waddr, ram_raddr;
  ios_pkg::entry_t                   ram_wdata, ram_rdata;
  logic [$bits(ios_pkg::entry_t)-1:0] ram_rdata_raw;

  logic                              full, empty, few2;
  logic [CmpW-1:0]                   cnt_x, pos_x;
  logic [AddrW-1:0]                  top_addr, cnt_addr, below_addr, idx_addr;
  logic [CntW-1:0]                   tgt;

  assign in_i.ready = (state_q == S_IDLE);
  assign ram_rdata  = ios_pkg::entry_t'(ram_rdata_raw);

  assign full       = (cnt_q == CntW'(STACK_DEPTH));
  assign empty      = (cnt_q == '0);
  assign few2       = (cnt_q < CntW'(2));
  assign cnt_x      = CmpW'(cnt_q);
  assign pos_x      = CmpW'(pos_q);
  assign top_addr   = AddrW'(cnt_q - CntW'(1));
  assign below_addr = AddrW'(cnt_q - CntW'(2));
  assign cnt_addr   = AddrW'(cnt_q);
  assign tgt        = cnt_q - CntW'(pos_q);
  assign idx_addr   = AddrW'(tgt - CntW'(1));

  // Item capture (payload only) plus the datapath registers, none of them reset.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      act_q <= in_i.action;
      pos_q <= in_i.position;
      val_q <= in_i.operand_value;
      typ_q <= in_i.operand_type;
    end
    ptr_q <= ptr_d;
    rem_q <= rem_d;
    tmp_q <= tmp_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    tmp_d     = tmp_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        res_d      = '0;
        res_d.err  = ios_pkg::ERR_OK;
        res_d.last = 1'b1;
        state_d    = S_EMIT;
        unique case (act_q) inside
          ios_pkg::ACT_PUSH: begin
            if (full) begin
              res_d.err = ios_pkg::ERR_OVERFLOW;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_addr;
              ram_wdata = '{value: val_q, etype: typ_q};
              cnt_d     = cnt_q + CntW'(1);
            end
          end
          ios_pkg::ACT_INSERT: begin
            if (pos_x > cnt_x) begin
              res_d.err = ios_pkg::ERR_RANGE;
            end else if (full) begin
              res_d.err = ios_pkg::ERR_OVERFLOW;
            end else if (pos_q == '0) begin
              ptr_d   = cnt_addr;
              state_d = S_PLACE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = top_addr;
              ptr_d     = top_addr;
              rem_d     = CntW'(pos_q);
              state_d   = S_UP;
            end
          end
          ios_pkg::ACT_POP: begin
            if (empty) begin
              res_d.err = ios_pkg::ERR_FEW;
            end else begin
              cnt_d = cnt_q - CntW'(1);
            end
          end
          ios_pkg::ACT_CLEAR: begin
            cnt_d = '0;
          end
          ios_pkg::ACT_DUP: begin
            if (empty) begin
              res_d.err = ios_pkg::ERR_FEW;
            end else if (full) begin
              res_d.err = ios_pkg::ERR_OVERFLOW;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = top_addr;
              state_d   = S_DUPW;
            end
          end
          ios_pkg::ACT_SWAP: begin
            if (few2) begin
              res_d.err = ios_pkg::ERR_FEW;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = top_addr;
              state_d   = S_SWAP1;
            end
          end
          ios_pkg::ACT_READ, ios_pkg::ACT_REMOVE: begin
            if (empty) begin
              res_d.err = ios_pkg::ERR_FEW;
            end else if (pos_x >= cnt_x) begin
              res_d.err = ios_pkg::ERR_RANGE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = idx_addr;
              ptr_d     = idx_addr;
              rem_d     = CntW'(pos_q);
              state_d   = S_FETCH;
            end
          end
          ios_pkg::ACT_PRINT: begin
            if (empty) begin
              res_d.err = ios_pkg::ERR_FEW;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = top_addr;
              state_d   = S_PRINT;
            end
          end
          ios_pkg::ACT_DUMP: begin
            if (!empty) begin
              ram_re    = 1'b1;
              ram_raddr = top_addr;
              ptr_d     = top_addr;
              state_d   = S_DUMP;
            end
          end
          default: begin
            // unused action codes: no-op, plain OK result
          end
        endcase
      end

      // insert: move entries one slot up, top first, one per cycle
      S_UP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q + AddrW'(1);
        ram_wdata = ram_rdata;
        if (rem_q > CntW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q - AddrW'(1);
          ptr_d     = ptr_q - AddrW'(1);
          rem_d     = rem_q - CntW'(1);
        end else begin
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = '{value: val_q, etype: typ_q};
        cnt_d     = cnt_q + CntW'(1);
        state_d   = S_EMIT;
      end

      S_DUPW: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_addr;
        ram_wdata = ram_rdata;
        cnt_d     = cnt_q + CntW'(1);
        state_d   = S_EMIT;
      end

      S_SWAP1: begin
        tmp_d     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = below_addr;
        state_d   = S_SWAP2;
      end

      S_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = top_addr;
        ram_wdata = ram_rdata;
        state_d   = S_SWAP3;
      end

      S_SWAP3: begin
        ram_we    = 1'b1;
        ram_waddr = below_addr;
        ram_wdata = tmp_q;
        state_d   = S_EMIT;
      end

      S_FETCH: begin
        res_d.value = ram_rdata.value;
        res_d.etype = ram_rdata.etype;
        state_d     = S_EMIT;
        if (act_q == ios_pkg::ACT_REMOVE) begin
          if (rem_q == '0) begin
            cnt_d = cnt_q - CntW'(1);
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q + AddrW'(1);
            ptr_d     = ptr_q + AddrW'(1);
            state_d   = S_DOWN;
          end
        end
      end

      // remove: close the gap, moving entries above it one slot down
      S_DOWN: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q - AddrW'(1);
        ram_wdata = ram_rdata;
        if (rem_q > CntW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + AddrW'(1);
          ptr_d     = ptr_q + AddrW'(1);
          rem_d     = rem_q - CntW'(1);
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_EMIT;
        end
      end

      S_PRINT: begin
        if (ram_rdata.etype != ios_pkg::TYPE_INT8) begin
          res_d.err = ios_pkg::ERR_NOT_INT8;
        end else begin
          res_d.value = ram_rdata.value;
        end
        state_d = S_EMIT;
      end

      S_DUMP: begin
        res_d.value = ram_rdata.value;
        res_d.etype = ram_rdata.etype;
        res_d.err   = ios_pkg::ERR_OK;
        res_d.last  = (ptr_q == '0);
        state_d     = S_EMIT;
      end

      S_EMIT: begin
        if (res_ready_i) begin
          if (res_q.last) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q - AddrW'(1);
            ptr_d     = ptr_q - AddrW'(1);
            state_d   = S_DUMP;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o       = res_q;
    res_o.count = ios_pkg::CountW'(cnt_q);
  end
  assign res_valid_o = (state_q == S_EMIT);

  ios_ram #(
    .Width ($bits(ios_pkg::entry_t)),
    .Depth (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

endmodule

`default_nettype wire
